>>> rtl/weighted_cell_statistics_accumulator_unit_defines.svh
// Assertion macros shared by the RTL.
`ifndef WEIGHTED_CELL_STATISTICS_ACCUMULATOR_UNIT_DEFINES_SVH
`define WEIGHTED_CELL_STATISTICS_ACCUMULATOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define WCSA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("wcsa assertion failed");
`define WCSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) \
      else $error("wcsa assertion failed");
`else
`define WCSA_ASSERT(label, clk, rst, prop)
`define WCSA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/wcsa_pkg.sv
package wcsa_pkg;

   localparam logic MODE_DIV  = 1'b0;
   localparam logic MODE_SQRT = 1'b1;

   localparam int ITER_COUNT = 32;
   localparam int CSR_AW     = 3;

   localparam logic REG_STATS_ENABLED   = 1'b0;
   localparam logic REG_SAMPLE_INTERVAL = 1'b1;

   localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic start;
      logic mode;
   } wcsa_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } wcsa_status_type;

   typedef struct packed {
      logic [47:0] sum;
      logic [31:0] mean;
      logic [63:0] msq;
   } wcsa_entry_type;

endpackage

>>> rtl/wcsa_req_if.sv
interface wcsa_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         property_index;
   logic               property_valid;
   logic [11:0]        cell_index;
   logic               cell_valid;
   logic [31:0]        step_index;
   logic [31:0]        time_step_size;
   logic [31:0]        sample_weight;
   logic signed [31:0] sample_value;

   modport source (output valid, property_index, property_valid, cell_index, cell_valid,
                   step_index, time_step_size, sample_weight, sample_value,
                   input ready);
   modport sink (input valid, property_index, property_valid, cell_index, cell_valid,
                 step_index, time_step_size, sample_weight, sample_value,
                 output ready);
endinterface

>>> rtl/wcsa_rsp_if.sv
interface wcsa_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         out_property;
   logic [11:0]        out_cell;
   logic [47:0]        weight_total;
   logic signed [31:0] running_mean;
   logic [63:0]        running_mean_square;
   logic [63:0]        variance;
   logic [31:0]        std_dev;

   modport source (output valid, out_property, out_cell, weight_total, running_mean,
                   running_mean_square, variance, std_dev,
                   input ready);
   modport sink (input valid, out_property, out_cell, weight_total, running_mean,
                 running_mean_square, variance, std_dev,
                 output ready);
endinterface

>>> rtl/wcsa_shiftsub.sv
// Shared shift-and-subtract unit: long division (one bit per cycle) or
// digit-by-digit square root (two bits per cycle), 32 steps either way.
module wcsa_shiftsub (
   input  logic                      clock,
   input  logic                      reset,
   input  wcsa_pkg::wcsa_cmd_type    cmd,
   input  logic [48:0]               r_init,
   input  logic [32:0]               q_init,
   input  logic [63:0]               src,
   input  logic [47:0]               divisor,
   output wcsa_pkg::wcsa_status_type status,
   output logic [32:0]               quo,
   output logic [48:0]               rem
);

   logic        mode_ff;
   logic [48:0] r_ff;
   logic [32:0] q_ff;
   logic [63:0] src_ff;
   logic [47:0] d_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [49:0] r2;
   logic [49:0] trial;
   logic [49:0] diff;
   logic        ge;
   logic [48:0] r_in;
   logic [63:0] src_in;

   always_comb begin
      if (mode_ff == wcsa_pkg::MODE_SQRT) begin
         r2     = {r_ff[47:0], src_ff[63:62]};
         trial  = {16'd0, q_ff[31:0], 2'b01};
         src_in = {src_ff[61:0], 2'b00};
      end else begin
         r2     = {r_ff, src_ff[63]};
         trial  = {2'd0, d_ff};
         src_in = {src_ff[62:0], 1'b0};
      end
      ge   = (r2 >= trial);
      diff = r2 - trial;
      r_in = ge ? diff[48:0] : r2[48:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'(wcsa_pkg::ITER_COUNT);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff <= cmd.mode;
         r_ff    <= r_init;
         q_ff    <= q_init;
         src_ff  <= src;
         d_ff    <= divisor;
      end else if (busy_ff) begin
         r_ff   <= r_in;
         q_ff   <= {q_ff[31:0], ge};
         src_ff <= src_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quo         = q_ff;
   assign rem         = r_ff;

endmodule

>>> rtl/weighted_cell_statistics_accumulator_unit.sv
// Weighted running mean / mean-square / variance per (property, cell) entry.
// After reset the entry memory is swept to zero, one entry a cycle over all
// MAX_PROPERTIES*MAX_CELLS entries, and no word is taken meanwhile (register
// writes are). One word is handled at a time. A dropped word (disabled,
// invalid entry) leaves the input ready, an off-interval step frees it once
// the step-interval division is done. A taken sample raises its result word
// after the shared 32-step shift-subtract unit has run for the step-interval
// remainder, the Q1.32 fraction (skipped when the new weight sum is zero)
// and the 64-bit square root, and uses a shared 32x32 multiplier.
// The result word is held in an output register, and the next word is taken
// while it waits.
`include "weighted_cell_statistics_accumulator_unit_defines.svh"

module weighted_cell_statistics_accumulator_unit #(
   parameter int MAX_PROPERTIES = 8,
   parameter int MAX_CELLS      = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   wcsa_req_if.sink                    req,
   wcsa_rsp_if.source                  rsp,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [wcsa_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   localparam int DEPTH = MAX_PROPERTIES * MAX_CELLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_MOD  = 4'd2;
   localparam logic [3:0] S_RD   = 4'd3;
   localparam logic [3:0] S_SUM  = 4'd4;
   localparam logic [3:0] S_DIV  = 4'd5;
   localparam logic [3:0] S_MA   = 4'd6;
   localparam logic [3:0] S_MB   = 4'd7;
   localparam logic [3:0] S_MC   = 4'd8;
   localparam logic [3:0] S_MD   = 4'd9;
   localparam logic [3:0] S_M2   = 4'd10;
   localparam logic [3:0] S_VAR  = 4'd11;
   localparam logic [3:0] S_SQRT = 4'd12;
   localparam logic [3:0] S_OUT  = 4'd13;

   logic [3:0]    state_ff;
   logic [AW-1:0] clr_ff;
   logic          en_ff;
   logic [15:0]   intv_ff;

   logic [2:0]         prop_ff;
   logic [11:0]        cell_ff;
   logic [31:0]        dt_ff;
   logic [31:0]        wt_ff;
   logic signed [31:0] z_ff;
   logic [AW-1:0]      addr_ff;

   logic [47:0]        inc_ff;
   logic [47:0]        sum_ff;
   logic signed [31:0] mean_ff;
   logic [63:0]        msq_ff;
   logic [63:0]        sq_ff;
   logic [32:0]        f_ff;
   logic [31:0]        plo_ff;
   logic [63:0]        var_ff;
   logic [63:0]        mul_ff;

   wcsa_pkg::wcsa_entry_type mem [DEPTH];
   wcsa_pkg::wcsa_entry_type rd_ff;
   wcsa_pkg::wcsa_entry_type wdata;
   logic                     we;
   logic [AW-1:0]            waddr;

   logic               rsp_valid_ff;
   logic [2:0]         rsp_prop_ff;
   logic [11:0]        rsp_cell_ff;
   logic [47:0]        rsp_sum_ff;
   logic signed [31:0] rsp_mean_ff;
   logic [63:0]        rsp_msq_ff;
   logic [63:0]        rsp_var_ff;
   logic [31:0]        rsp_std_ff;

   wcsa_pkg::wcsa_cmd_type    cmd;
   wcsa_pkg::wcsa_status_type status;
   logic [48:0]               r_init;
   logic [32:0]               q_init;
   logic [63:0]               src;
   logic [47:0]               divisor;
   logic [32:0]               quo;
   logic [48:0]               rem;

   logic          accept;
   logic          entry_ok;
   logic [15:0]   intv_eff;
   logic [AW-1:0] addr_in;
   logic [47:0]   inc_in;
   logic [48:0]   sum_wide;
   logic [47:0]   sum_in;
   logic          z_ge;
   logic [32:0]   dz;
   logic [32:0]   ndz;
   logic [31:0]   dm;
   logic [31:0]   step_m;
   logic [32:0]   mean_wide;
   logic          sq_ge;
   logic [63:0]   dq;
   logic [63:0]   step_q;
   logic [63:0]   msq_in;
   logic [31:0]   zmag;
   logic [31:0]   mmag;
   logic [63:0]   var_in;
   logic [31:0]   op_a;
   logic [31:0]   op_b;
   logic          rsp_free;

   // register port
   assign pready = 1'b1;
   always_comb begin
      case (paddr[2])
         wcsa_pkg::REG_STATS_ENABLED:   prdata = {31'd0, en_ff};
         wcsa_pkg::REG_SAMPLE_INTERVAL: prdata = {16'd0, intv_ff};
         default:                       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff   <= 1'b1;
         intv_ff <= 16'd1;
      end else if (psel && penable && pwrite) begin
         case (paddr[2])
            wcsa_pkg::REG_STATS_ENABLED:   en_ff   <= pwdata[0];
            wcsa_pkg::REG_SAMPLE_INTERVAL: intv_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // input side
   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign entry_ok  = en_ff && req.property_valid && req.cell_valid &&
                      ({29'd0, req.property_index} < 32'(MAX_PROPERTIES)) &&
                      ({20'd0, req.cell_index} < 32'(MAX_CELLS));
   assign intv_eff  = (intv_ff == 16'd0) ? 16'd1 : intv_ff;
   assign addr_in   = AW'(int'(req.property_index) * MAX_CELLS + int'(req.cell_index));

   // datapath
   assign inc_in   = mul_ff[63:16];
   assign sum_wide = {1'b0, rd_ff.sum} + {1'b0, inc_in};
   assign sum_in   = sum_wide[48] ? wcsa_pkg::SUM_MAX : sum_wide[47:0];

   assign z_ge   = (z_ff >= mean_ff);
   assign dz     = {z_ff[31], z_ff} - {mean_ff[31], mean_ff};
   assign ndz    = -dz;
   assign dm     = z_ge ? dz[31:0] : ndz[31:0];
   assign step_m = f_ff[32] ? dm : mul_ff[63:32];
   assign mean_wide = z_ge ? ({mean_ff[31], mean_ff} + {1'b0, step_m})
                           : ({mean_ff[31], mean_ff} - {1'b0, step_m});

   assign sq_ge  = (sq_ff >= msq_ff);
   assign dq     = sq_ge ? (sq_ff - msq_ff) : (msq_ff - sq_ff);
   assign step_q = f_ff[32] ? dq : (mul_ff + {32'd0, plo_ff});
   assign msq_in = sq_ge ? (msq_ff + step_q) : (msq_ff - step_q);

   assign zmag   = z_ff[31] ? (~z_ff + 32'd1) : z_ff;
   assign mmag   = mean_ff[31] ? (~mean_ff + 32'd1) : mean_ff;
   assign var_in = (msq_ff > mul_ff) ? (msq_ff - mul_ff) : 64'd0;

   // shared multiplier operands
   always_comb begin
      case (state_ff)
         S_MOD: begin
            op_a = wt_ff;
            op_b = dt_ff;
         end
         S_RD: begin
            op_a = zmag;
            op_b = zmag;
         end
         S_MA: begin
            op_a = dm;
            op_b = f_ff[31:0];
         end
         S_MB: begin
            op_a = dq[31:0];
            op_b = f_ff[31:0];
         end
         S_MC: begin
            op_a = dq[63:32];
            op_b = f_ff[31:0];
         end
         S_M2: begin
            op_a = mmag;
            op_b = mmag;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mul_ff <= {32'd0, op_a} * {32'd0, op_b};
   end

   // shift-subtract unit commands
   always_comb begin
      cmd     = '0;
      r_init  = '0;
      q_init  = '0;
      src     = '0;
      divisor = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.start = accept && entry_ok;
            cmd.mode  = wcsa_pkg::MODE_DIV;
            src       = {req.step_index, 32'd0};
            divisor   = {32'd0, intv_eff};
         end
         S_SUM: begin
            cmd.start = (sum_ff != 48'd0);
            cmd.mode  = wcsa_pkg::MODE_DIV;
            if (inc_ff >= sum_ff) begin
               r_init = {1'b0, inc_ff - sum_ff};
               q_init = 33'd1;
            end else begin
               r_init = {1'b0, inc_ff};
               q_init = 33'd0;
            end
            divisor = sum_ff;
         end
         S_VAR: begin
            cmd.start = 1'b1;
            cmd.mode  = wcsa_pkg::MODE_SQRT;
            src       = var_in;
         end
         default: ;
      endcase
   end

   wcsa_shiftsub u_shiftsub (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .r_init  (r_init),
      .q_init  (q_init),
      .src     (src),
      .divisor (divisor),
      .status  (status),
      .quo     (quo),
      .rem     (rem)
   );

   // entry memory
   assign we    = (state_ff == S_CLR) || (state_ff == S_VAR);
   assign waddr = (state_ff == S_CLR) ? clr_ff : addr_ff;
   always_comb begin
      if (state_ff == S_CLR) begin
         wdata = '0;
      end else begin
         wdata.sum  = sum_ff;
         wdata.mean = mean_ff;
         wdata.msq  = msq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[addr_ff];
   end

   assign rsp_free = !rsp_valid_ff || rsp.ready;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
      end else begin
         case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: if (accept && entry_ok) state_ff <= S_MOD;
            S_MOD: begin
               if (status.done) begin
                  state_ff <= (rem == 49'd0) ? S_RD : S_IDLE;
               end
            end
            S_RD:   state_ff <= S_SUM;
            S_SUM:  state_ff <= (sum_ff != 48'd0) ? S_DIV : S_M2;
            S_DIV:  if (status.done) state_ff <= S_MA;
            S_MA:   state_ff <= S_MB;
            S_MB:   state_ff <= S_MC;
            S_MC:   state_ff <= S_MD;
            S_MD:   state_ff <= S_M2;
            S_M2:   state_ff <= S_VAR;
            S_VAR:  state_ff <= S_SQRT;
            S_SQRT: if (status.done) state_ff <= S_OUT;
            S_OUT:  if (rsp_free) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prop_ff <= req.property_index;
         cell_ff <= req.cell_index;
         dt_ff   <= req.time_step_size;
         wt_ff   <= req.sample_weight;
         z_ff    <= req.sample_value;
         addr_ff <= addr_in;
      end
      case (state_ff)
         S_RD: begin
            inc_ff  <= inc_in;
            sum_ff  <= sum_in;
            mean_ff <= rd_ff.mean;
            msq_ff  <= rd_ff.msq;
         end
         S_SUM:  sq_ff <= mul_ff;
         S_DIV:  if (status.done) f_ff <= quo;
         S_MB:   mean_ff <= mean_wide[31:0];
         S_MC:   plo_ff <= mul_ff[63:32];
         S_MD:   msq_ff <= msq_in;
         S_VAR:  var_ff <= var_in;
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_OUT && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && rsp_free) begin
         rsp_prop_ff <= prop_ff;
         rsp_cell_ff <= cell_ff;
         rsp_sum_ff  <= sum_ff;
         rsp_mean_ff <= mean_ff;
         rsp_msq_ff  <= msq_ff;
         rsp_var_ff  <= var_ff;
         rsp_std_ff  <= quo[31:0];
      end
   end

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.out_property        = rsp_prop_ff;
   assign rsp.out_cell            = rsp_cell_ff;
   assign rsp.weight_total        = rsp_sum_ff;
   assign rsp.running_mean        = rsp_mean_ff;
   assign rsp.running_mean_square = rsp_msq_ff;
   assign rsp.variance            = rsp_var_ff;
   assign rsp.std_dev             = rsp_std_ff;

   `WCSA_ASSERT(a_start_when_free, clock, reset, cmd.start |-> !status.busy)
   `WCSA_ASSERT(a_div_nonzero_sum, clock, reset, (state_ff == S_DIV) |-> (sum_ff != 48'd0))
   `WCSA_ASSERT_NEXT(a_out_holds, clock, reset, (state_ff == S_OUT) && !rsp_free, (state_ff == S_OUT))

endmodule

>>> test/weighted_cell_statistics_accumulator_unit_test_ifs.sv
// Channel interfaces come from the RTL folder.

>>> test/weighted_cell_statistics_accumulator_unit_test.sv
module weighted_cell_statistics_accumulator_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PROPS = 8;
   localparam int NUM_CELLS = 4096;
   localparam int SETTLE_CYCLES = 150;

   typedef struct packed {
      logic [2:0]         prop;
      logic               prop_ok;
      logic [11:0]        cell_idx;
      logic               cell_ok;
      logic [31:0]        step;
      logic [31:0]        dt;
      logic [31:0]        wt;
      logic signed [31:0] value;
   } sample_t;

   typedef struct packed {
      logic [2:0]         prop;
      logic [11:0]        cell_idx;
      logic [47:0]        sum;
      logic signed [31:0] mean;
      logic [63:0]        msq;
      logic [63:0]        var_q;
      logic [31:0]        sdev;
   } stats_t;

   typedef struct packed {
      sample_t    s;
      logic       typed;
      stats_t     want;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [wcsa_pkg::CSR_AW-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   wcsa_req_if req ();
   wcsa_rsp_if rsp ();

   weighted_cell_statistics_accumulator_unit u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic [47:0] sum_tbl [int];
   logic [31:0] mean_tbl [int];
   logic [63:0] msq_tbl [int];
   logic        cfg_enabled = 1'b1;
   logic [15:0] cfg_interval = 16'd1;

   stats_t pending_stats [$];
   int     error_count = 0;
   int     results_seen = 0;
   bit     hold_off_request = 0;

   function automatic logic [63:0] frac_q32(logic [63:0] num, logic [63:0] den);
      logic [63:0] q, r;
      q = 0;
      if (num >= den) begin
         q = 1;
         r = num - den;
      end else begin
         r = num;
      end
      for (int i = 0; i < 32; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] scale_frac(logic [63:0] a, logic [63:0] f);
      if (f >= 64'h1_0000_0000) return a;
      return (a >> 32) * f + (({32'd0, a[31:0]} * f) >> 32);
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // updates the tables; returns 1 when the sample yields a word
   function automatic bit accumulate(sample_t s, output stats_t o);
      logic [31:0] ival;
      logic [63:0] inc, sum, msq, sq, m2, f, zmag, mmag;
      longint mean, z;
      int key;
      if (!cfg_enabled) return 0;
      ival = (cfg_interval == 0) ? 32'd1 : {16'd0, cfg_interval};
      if (s.step % ival != 0) return 0;
      if (!s.prop_ok || !s.cell_ok || s.prop >= NUM_PROPS || s.cell_idx >= NUM_CELLS)
         return 0;
      key = s.prop * NUM_CELLS + s.cell_idx;
      inc = ({32'd0, s.wt} * {32'd0, s.dt}) >> 16;
      sum = (sum_tbl.exists(key) ? {16'd0, sum_tbl[key]} : 64'd0) + inc;
      if (sum > {16'd0, wcsa_pkg::SUM_MAX}) sum = {16'd0, wcsa_pkg::SUM_MAX};
      sum_tbl[key] = sum[47:0];
      mean = mean_tbl.exists(key) ? longint'(signed'(mean_tbl[key])) : 0;
      msq = msq_tbl.exists(key) ? msq_tbl[key] : 64'd0;
      z = longint'(s.value);
      zmag = (z < 0) ? -z : z;
      sq = zmag * zmag;
      if (sum != 0) begin
         f = frac_q32(inc, sum);
         if (z >= mean) mean = mean + longint'(scale_frac(z - mean, f));
         else mean = mean - longint'(scale_frac(mean - z, f));
         if (sq >= msq) msq = msq + scale_frac(sq - msq, f);
         else msq = msq - scale_frac(msq - sq, f);
         mean_tbl[key] = mean[31:0];
         msq_tbl[key] = msq;
      end
      mmag = (mean < 0) ? -mean : mean;
      m2 = mmag * mmag;
      o.prop = s.prop;
      o.cell_idx = s.cell_idx;
      o.sum = sum[47:0];
      o.mean = mean[31:0];
      o.msq = msq;
      o.var_q = (msq > m2) ? msq - m2 : 64'd0;
      o.sdev = 32'(int_sqrt(o.var_q));
      return 1;
   endfunction

   task automatic csr_write(logic reg_idx, logic [31:0] data);
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = {reg_idx, 2'b00};
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      if (reg_idx == wcsa_pkg::REG_STATS_ENABLED) cfg_enabled = data[0];
      else cfg_interval = data[15:0];
   endtask

   // offer one word from the falling edge until accepted
   task automatic send_sample(sample_t s, bit typed, stats_t typed_want);
      stats_t pred;
      @(negedge clock);
      req.valid = 1'b1;
      req.property_index = s.prop;
      req.property_valid = s.prop_ok;
      req.cell_index = s.cell_idx;
      req.cell_valid = s.cell_ok;
      req.step_index = s.step;
      req.time_step_size = s.dt;
      req.sample_weight = s.wt;
      req.sample_value = s.value;
      do @(posedge clock); while (!req.ready);
      if (accumulate(s, pred)) pending_stats.push_back(typed ? typed_want : pred);
   endtask

   task automatic idle_sender(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req.valid = 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      idle_sender(1);
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_q16();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2, 3: return $urandom;
         default: return $urandom_range(32'h100, 32'h3_0000);
      endcase
   endfunction

   function automatic sample_t random_sample();
      sample_t s;
      logic [31:0] ival;
      ival = (cfg_interval == 0) ? 32'd1 : {16'd0, cfg_interval};
      s.prop = 3'($urandom);
      s.prop_ok = ($urandom_range(0, 15) != 0);
      s.cell_idx = ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                               : 12'($urandom_range(0, 5) * 683);
      s.cell_ok = ($urandom_range(0, 15) != 0);
      if ($urandom_range(0, 7) < 6) s.step = $urandom_range(0, 32'hFFFF_FFFF / ival) * ival;
      else s.step = $urandom;
      s.dt = pick_q16();
      s.wt = pick_q16();
      case ($urandom_range(0, 5))
         0: s.value = 32'sh7FFF_FFFF;
         1: s.value = 32'sh8000_0000;
         2, 3: s.value = $urandom;
         default: s.value = $urandom_range(0, 32'h000A_0000) - 32'h0005_0000;
      endcase
      return s;
   endfunction

   task automatic random_phase(int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && count > 0) begin
            send_sample(random_sample(), 1'b0, '0);
            burst--;
            count--;
         end
         idle_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40));
      end
   endtask

   row_t directed [] = '{
      // fresh entry, full weight: mean jumps to the sample, variance zero
      '{'{3'd0, 1'b1, 12'd0, 1'b1, 32'd0, 32'h1_0000, 32'h1_0000, 32'sh2_0000}, 1'b1,
        '{3'd0, 12'd0, 48'h1_0000, 32'sh2_0000, 64'h4_0000_0000, 64'd0, 32'd0}},
      // zero increment on a fresh entry leaves everything zero
      '{'{3'd1, 1'b1, 12'd5, 1'b1, 32'd7, 32'd0, 32'h1_0000, 32'sh5_0000}, 1'b1,
        '{3'd1, 12'd5, 48'd0, 32'sd0, 64'd0, 64'd0, 32'd0}},
      '{'{3'd0, 1'b1, 12'd0, 1'b1, 32'd1, 32'h1_0000, 32'h1_0000, 32'sh4_0000}, 1'b0, '0},
      '{'{3'd0, 1'b1, 12'd0, 1'b1, 32'd2, 32'h8000, 32'h3_0000, -32'sh1_0000}, 1'b0, '0},
      '{'{3'd7, 1'b1, 12'd4095, 1'b1, 32'hFFFF_FFFF, 32'h1_0000, 32'h1_0000,
          32'sh7FFF_FFFF}, 1'b0, '0},
      '{'{3'd7, 1'b1, 12'd4095, 1'b1, 32'd3, 32'h1_0000, 32'h2_0000,
          32'sh8000_0000}, 1'b0, '0},
      // invalid property or cell: dropped
      '{'{3'd2, 1'b0, 12'd9, 1'b1, 32'd4, 32'h1_0000, 32'h1_0000, 32'sh1_0000}, 1'b0, '0},
      '{'{3'd2, 1'b1, 12'd9, 1'b0, 32'd4, 32'h1_0000, 32'h1_0000, 32'sh1_0000}, 1'b0, '0},
      '{'{3'd2, 1'b0, 12'd9, 1'b0, 32'd4, 32'h1_0000, 32'h1_0000, 32'sh1_0000}, 1'b0, '0},
      // largest increments: weight sum saturates
      '{'{3'd3, 1'b1, 12'd100, 1'b1, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'sh0010_0000}, 1'b0, '0},
      '{'{3'd3, 1'b1, 12'd100, 1'b1, 32'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          -32'sh0020_0000}, 1'b0, '0},
      '{'{3'd3, 1'b1, 12'd100, 1'b1, 32'd7, 32'h1_0000, 32'h1_0000, 32'sh7FFF_FFFF}, 1'b0, '0},
      '{'{3'd4, 1'b1, 12'd2048, 1'b1, 32'd8, 32'd1, 32'd1, 32'sh1_0000}, 1'b0, '0},
      '{'{3'd4, 1'b1, 12'd2048, 1'b1, 32'd9, 32'h1_0000, 32'h1_0000, 32'sh3_0000}, 1'b0, '0},
      '{'{3'd5, 1'b1, 12'd1, 1'b1, 32'd10, 32'hFFFF_FFFF, 32'h1, 32'sh8000_0000}, 1'b0, '0},
      '{'{3'd5, 1'b1, 12'd1, 1'b1, 32'd11, 32'h1, 32'hFFFF_FFFF, 32'sh7FFF_FFFF}, 1'b0, '0},
      '{'{3'd6, 1'b1, 12'hAAA, 1'b1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
          32'sh5555_5555}, 1'b0, '0},
      '{'{3'd6, 1'b1, 12'hAAA, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
          32'shAAAA_AAAA}, 1'b0, '0}
   };

   // result checker
   always @(posedge clock) begin
      stats_t got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.out_property, rsp.out_cell, rsp.weight_total, rsp.running_mean,
                 rsp.running_mean_square, rsp.variance, rsp.std_dev};
         results_seen++;
         if (pending_stats.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, got);
            error_count++;
         end else begin
            want = pending_stats.pop_front();
            if (got.prop !== want.prop) begin
               $display("%0t: out_property exp %0d got %0d", $time, want.prop, got.prop);
               error_count++;
            end
            if (got.cell_idx !== want.cell_idx) begin
               $display("%0t: out_cell exp %0d got %0d", $time, want.cell_idx, got.cell_idx);
               error_count++;
            end
            if (got.sum !== want.sum) begin
               $display("%0t: weight_total exp %h got %h", $time, want.sum, got.sum);
               error_count++;
            end
            if (got.mean !== want.mean) begin
               $display("%0t: running_mean exp %h got %h", $time, want.mean, got.mean);
               error_count++;
            end
            if (got.msq !== want.msq) begin
               $display("%0t: running_mean_square exp %h got %h", $time, want.msq, got.msq);
               error_count++;
            end
            if (got.var_q !== want.var_q) begin
               $display("%0t: variance exp %h got %h", $time, want.var_q, got.var_q);
               error_count++;
            end
            if (got.sdev !== want.sdev) begin
               $display("%0t: std_dev exp %h got %h", $time, want.sdev, got.sdev);
               error_count++;
            end
         end
      end
   end

   // receiver: pattern of its own, plus one long hold-off on request
   initial begin
      int mode_left, mode, hold_left;
      mode_left = 0;
      mode = 0;
      hold_left = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 0;
            hold_left = 600;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready = 1'b0;
         end else begin
            case (mode)
               0: rsp.ready = 1'b1;
               1: rsp.ready = 1'($urandom_range(0, 1));
               2: rsp.ready = ($urandom_range(0, 3) == 0);
               default: rsp.ready = ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin
      req.valid = 1'b0;
      req.property_index = '0;
      req.property_valid = 1'b0;
      req.cell_index = '0;
      req.cell_valid = 1'b0;
      req.step_index = '0;
      req.time_step_size = '0;
      req.sample_weight = '0;
      req.sample_value = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         send_sample(directed[i].s, directed[i].typed, directed[i].want);
         if (i % 5 == 4) idle_sender($urandom_range(1, 10));
      end
      drain();

      csr_write(wcsa_pkg::REG_SAMPLE_INTERVAL, 32'd3);
      hold_off_request = 1;
      random_phase(225);
      drain();
      csr_write(wcsa_pkg::REG_STATS_ENABLED, 32'd0);
      random_phase(60);
      drain();
      csr_write(wcsa_pkg::REG_STATS_ENABLED, 32'd1);
      csr_write(wcsa_pkg::REG_SAMPLE_INTERVAL, 32'd65535);
      random_phase(200);
      drain();
      // interval zero behaves as one
      csr_write(wcsa_pkg::REG_SAMPLE_INTERVAL, 32'd0);
      random_phase(300);
      drain();
      csr_write(wcsa_pkg::REG_SAMPLE_INTERVAL, 32'd2);
      random_phase(250);
      drain();
      csr_write(wcsa_pkg::REG_SAMPLE_INTERVAL, 32'd1);
      random_phase(300);
      drain();

      if (error_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #8ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/wcsa_pkg.sv
rtl/wcsa_req_if.sv
rtl/wcsa_rsp_if.sv
rtl/wcsa_shiftsub.sv
rtl/weighted_cell_statistics_accumulator_unit.sv
test/weighted_cell_statistics_accumulator_unit_test_ifs.sv
test/weighted_cell_statistics_accumulator_unit_test.sv
